>>> design/qjad_pkg.sv
// Package for the quadtree job area decoder.
// Holds shared constants, register indexes, quadrant codes and the
// controller/datapath command and status types. No dependencies.
package qjad_pkg;

    localparam int MAX_LEVELS_DEF = 16;
    localparam int JOB_W          = 32;
    localparam int COORD_W        = 32;
    localparam int CFG_W          = 15;
    localparam int CFG_IDX_W      = 1;
    localparam logic [CFG_W-1:0] SIZE_RESET = 15'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_idx;

    // quadrant digit minus one
    typedef enum logic [1:0] {
        QUAD_TL = 2'd0,
        QUAD_TR = 2'd1,
        QUAD_BR = 2'd2,
        QUAD_BL = 2'd3
    } t_quad;

    typedef struct packed {
        logic load;
        logic split;
        logic walk;
        logic sums;
        logic bounds;
    } t_cmd;

    typedef struct packed {
        logic job_zero;
        logic count_full;
        logic stack_empty;
        logic out_free;
    } t_stat;

endpackage

>>> design/qjad_job_if.sv
// Input channel of the quadtree job area decoder: one job number per transaction.
// Depends on qjad_pkg.
interface qjad_job_if;
    logic                          valid;
    logic                          ready;
    logic [qjad_pkg::JOB_W-1:0]    job_index;

    modport source (output valid, output job_index, input ready);
    modport sink   (input valid, input job_index, output ready);
endinterface

>>> design/qjad_area_if.sv
// Output channel of the quadtree job area decoder: one rectangle per transaction.
// Depends on qjad_pkg.
interface qjad_area_if;
    logic                          valid;
    logic                          ready;
    logic [qjad_pkg::COORD_W-1:0]  x_first;
    logic [qjad_pkg::COORD_W-1:0]  y_first;
    logic [qjad_pkg::COORD_W-1:0]  x_last;
    logic [qjad_pkg::COORD_W-1:0]  y_last;

    modport source (output valid, output x_first, output y_first, output x_last,
                    output y_last, input ready);
    modport sink   (input valid, input x_first, input y_first, input x_last,
                    input y_last, output ready);
endinterface

>>> design/qjad_ctrl.sv
// Controller of the quadtree job area decoder: sequences load, digit split,
// level walk and bound computation. Depends on qjad_pkg.
module qjad_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  qjad_pkg::t_stat  i_stat,
    output qjad_pkg::t_cmd   o_cmd
);
    import qjad_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_WALK,
        ST_SUMS,
        ST_BOUNDS
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                if (i_stat.job_zero || i_stat.count_full) begin
                    n_state = ST_WALK;
                end else begin
                    o_cmd.split = 1'b1;
                end
            end
            ST_WALK: begin
                if (i_stat.stack_empty) begin
                    n_state = ST_SUMS;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            ST_SUMS: begin
                o_cmd.sums = 1'b1;
                n_state    = ST_BOUNDS;
            end
            ST_BOUNDS: begin
                if (i_stat.out_free) begin
                    o_cmd.bounds = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

endmodule

>>> design/qjad_dp.sv
// Datapath of the quadtree job area decoder: config registers, digit stack,
// fixed-point centre walk, border offsets and output register. Depends on qjad_pkg.
module qjad_dp #(
    parameter int MAX_LEVELS = qjad_pkg::MAX_LEVELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qjad_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qjad_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic [qjad_pkg::JOB_W-1:0]      i_job_index,
    input  qjad_pkg::t_cmd                  i_cmd,
    output qjad_pkg::t_stat                 o_stat,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [qjad_pkg::COORD_W-1:0]    o_x_first,
    output logic [qjad_pkg::COORD_W-1:0]    o_y_first,
    output logic [qjad_pkg::COORD_W-1:0]    o_x_last,
    output logic [qjad_pkg::COORD_W-1:0]    o_y_last
);
    import qjad_pkg::*;

    localparam int LVL_W = $clog2(MAX_LEVELS + 1);
    localparam int SH_W  = LVL_W + 1;
    localparam int STK_W = 2 * MAX_LEVELS;

    logic [CFG_W-1:0]   r_width;
    logic [CFG_W-1:0]   r_height;
    logic [JOB_W-1:0]   r_job;
    logic [STK_W-1:0]   r_stack;
    logic [LVL_W-1:0]   r_count;
    logic [LVL_W-1:0]   r_level;
    logic [COORD_W-1:0] r_xz;
    logic [COORD_W-1:0] r_yz;
    logic [LVL_W-1:0]   r_left;
    logic [LVL_W-1:0]   r_right;
    logic [LVL_W-1:0]   r_top;
    logic [LVL_W-1:0]   r_bottom;
    logic [COORD_W-1:0] r_xlo;
    logic [COORD_W-1:0] r_xhi;
    logic [COORD_W-1:0] r_ylo;
    logic [COORD_W-1:0] r_yhi;
    logic               r_out_valid;
    logic [COORD_W-1:0] r_x_first;
    logic [COORD_W-1:0] r_y_first;
    logic [COORD_W-1:0] r_x_last;
    logic [COORD_W-1:0] r_y_last;

    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [JOB_W-1:0]   jm1;
    logic [STK_W+1:0]   push;
    t_quad              quad;
    logic               east;
    logic               south;
    logic [LVL_W-1:0]   step;
    logic [SH_W-1:0]    sh;
    logic [COORD_W-1:0] x_up;
    logic [COORD_W-1:0] y_up;

    assign sx    = COORD_W'(r_width) - COORD_W'(1);
    assign sy    = COORD_W'(r_height) - COORD_W'(1);
    assign jm1   = r_job - JOB_W'(1);
    assign push  = {r_stack, jm1[1:0]};
    assign quad  = t_quad'(r_stack[1:0]);
    assign east  = (quad == QUAD_TR) || (quad == QUAD_BR);
    assign south = (quad == QUAD_BR) || (quad == QUAD_BL);
    assign step  = (r_level != '0) ? LVL_W'(1) : '0;
    assign sh    = SH_W'(r_level) + SH_W'(1);
    assign x_up  = (r_xlo == '0) ? '0 : (r_xlo >> sh) + COORD_W'(1);
    assign y_up  = (r_ylo == '0) ? '0 : (r_ylo >> sh) + COORD_W'(1);

    assign o_stat.job_zero    = (r_job == '0);
    assign o_stat.count_full  = (r_count == LVL_W'(MAX_LEVELS));
    assign o_stat.stack_empty = (r_count == '0);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_RESET;
            r_height <= SIZE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SCREEN_WIDTH) begin
                r_width <= i_cfg_wdata;
            end
            if (i_cfg_idx == CFG_SCREEN_HEIGHT) begin
                r_height <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_job    <= i_job_index;
            r_count  <= '0;
            r_level  <= '0;
            r_xz     <= sx;
            r_yz     <= sy;
            r_left   <= '0;
            r_right  <= '0;
            r_top    <= '0;
            r_bottom <= '0;
        end
        if (i_cmd.split) begin
            r_stack <= push[STK_W-1:0];
            r_job   <= jm1 >> 2;
            r_count <= r_count + LVL_W'(1);
        end
        if (i_cmd.walk) begin
            r_stack <= r_stack >> 2;
            r_count <= r_count - LVL_W'(1);
            r_level <= r_level + LVL_W'(1);
            r_xz    <= east ? (r_xz << 1) + sx : (r_xz << 1) - sx;
            r_yz    <= south ? (r_yz << 1) + sy : (r_yz << 1) - sy;
            if (east) begin
                r_left  <= '0;
                r_right <= r_right + step;
            end else begin
                r_right <= '0;
                r_left  <= r_left + step;
            end
            if (south) begin
                r_top    <= '0;
                r_bottom <= r_bottom + step;
            end else begin
                r_bottom <= '0;
                r_top    <= r_top + step;
            end
        end
        if (i_cmd.sums) begin
            r_xlo <= r_xz - sx;
            r_xhi <= r_xz + sx;
            r_ylo <= r_yz - sy;
            r_yhi <= r_yz + sy;
        end
        if (i_cmd.bounds) begin
            r_x_first <= x_up + COORD_W'(r_left);
            r_y_first <= y_up + COORD_W'(r_top);
            r_x_last  <= (r_xhi >> sh) - COORD_W'(r_right);
            r_y_last  <= (r_yhi >> sh) - COORD_W'(r_bottom);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.bounds) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_x_first   = r_x_first;
    assign o_y_first   = r_y_first;
    assign o_x_last    = r_x_last;
    assign o_y_last    = r_y_last;

endmodule

>>> design/quadtree_job_area_decode_core.sv
// Top level of the quadtree job area decoder.
// Depends on qjad_pkg, qjad_job_if, qjad_area_if, qjad_ctrl and qjad_dp.
//
// Turns a job number of an implicit 4-ary screen tree (0 is the whole screen,
// children of j are 4j+1..4j+4) into the first and last column and row of its
// rectangle. A job has n quadrant digits, n up to MAX_LEVELS (16 at most for
// a 32-bit job). The controller splits the job number into digits until it
// is zero or the stack is full, walks the centre down the tree one digit per
// step until the stack is empty, then forms the sums and the bounds and goes
// back to idle to take the next job. A previous result still waiting to be
// taken holds the final bounds step. Only one job is in flight; the result
// register lets a new job start while a finished rectangle waits to be taken.
// Screen size registers are to be written only while idle; the block itself
// does not enforce this.
module quadtree_job_area_decode_core #(
    parameter int MAX_LEVELS = qjad_pkg::MAX_LEVELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qjad_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qjad_pkg::CFG_W-1:0]      i_cfg_wdata,
    qjad_job_if.sink                        i_job,
    qjad_area_if.source                     o_area
);
    import qjad_pkg::*;

    t_cmd  s_cmd;
    t_stat s_stat;

    qjad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_job.valid),
        .o_ready (i_job.ready),
        .i_stat  (s_stat),
        .o_cmd   (s_cmd)
    );

    qjad_dp #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job_index (i_job.job_index),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .i_out_ready (o_area.ready),
        .o_out_valid (o_area.valid),
        .o_x_first   (o_area.x_first),
        .o_y_first   (o_area.y_first),
        .o_x_last    (o_area.x_last),
        .o_y_last    (o_area.y_last)
    );

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(s_cmd))
        else $error("more than one datapath command at once");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job.valid && i_job.ready |=> !i_job.ready)
        else $error("ready right after an accepted job");

    a_split_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.split |-> !s_stat.count_full && !s_stat.job_zero)
        else $error("digit split past the stack depth or on a finished job");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.walk |-> !s_stat.stack_empty)
        else $error("walk step with an empty digit stack");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.bounds |-> s_stat.out_free)
        else $error("result register overwritten before it was taken");

endmodule
